// ===== sv/utf8_display_text_validator_core_macros.svh =====
// Assertion macros shared by the UTF-8 display text validator checker.
`ifndef UTF8_DISPLAY_TEXT_VALIDATOR_CORE_MACROS_SVH
`define UTF8_DISPLAY_TEXT_VALIDATOR_CORE_MACROS_SVH

// Checked on every edge except while reset is held.
`define UTF8DV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define UTF8DV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/utf8dv_pkg.sv =====
// Package with the constants and helpers of the UTF-8 display text validator.
`default_nettype none

package utf8dv_pkg;

    localparam int unsigned CpWidth = 21;

    typedef logic [7:0]         t_byte;
    typedef logic [1:0]         t_pending;
    typedef logic [CpWidth-1:0] t_code_point;

    typedef enum logic [1:0] {
        MIN_CLASS_2BYTE = 2'd0,
        MIN_CLASS_3BYTE = 2'd1,
        MIN_CLASS_4BYTE = 2'd2,
        MIN_CLASS_SPARE = 2'd3
    } t_min_class;

    localparam t_byte       C_SPACE       = 8'h20;
    localparam t_byte       C_DEL         = 8'h7f;
    localparam t_byte       C_LEAD2_LO    = 8'hc2;
    localparam t_byte       C_LEAD2_HI    = 8'hdf;
    localparam t_byte       C_LEAD3_LO    = 8'he0;
    localparam t_byte       C_LEAD3_HI    = 8'hef;
    localparam t_byte       C_LEAD4_LO    = 8'hf0;
    localparam t_byte       C_LEAD4_HI    = 8'hf4;
    localparam t_byte       C_CONT_MASK   = 8'hc0;
    localparam t_byte       C_CONT_TAG    = 8'h80;
    localparam t_code_point C_CP_MAX      = 21'h10ffff;
    localparam t_code_point C_SURR_LO     = 21'h00d800;
    localparam t_code_point C_SURR_HI     = 21'h00dfff;
    localparam t_code_point C_MIN_2BYTE   = 21'h000080;
    localparam t_code_point C_MIN_3BYTE   = 21'h000800;
    localparam t_code_point C_MIN_4BYTE   = 21'h010000;

    // Smallest code point that a sequence of the given class may encode.
    function automatic t_code_point min_for_class(input t_min_class cls);
        t_code_point v;
        unique case (cls)
            MIN_CLASS_2BYTE: v = C_MIN_2BYTE;
            MIN_CLASS_3BYTE: v = C_MIN_3BYTE;
            default:         v = C_MIN_4BYTE;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/utf8_display_text_validator_core.sv =====
// Top level of the UTF-8 display text validator: byte checker with one verdict per string.
// The block takes a text string one byte per transfer on the input channel
// (i_in_valid / o_in_ready) with i_last_byte marking the final byte, or a single
// transfer with i_empty_string set for an empty string. It returns one verdict per
// string on the output channel (o_out_valid / i_out_ready): o_string_valid is 1 when
// the string is well-formed UTF-8 without control characters below 0x20, DEL, overlong forms,
// surrogates or code points above 0x10FFFF.
// Every byte passes an input register and then decode logic that updates the
// sequence state; the verdict sits in an output register, loaded when the final
// byte is consumed from the input register. One byte is taken every cycle unless
// a final byte waits for a stalled verdict, so throughput is one byte per cycle,
// set by the single state update.
// If the receiver stalls, the verdict holds; bytes that end no string keep
// flowing, and the next final byte waits in the input register until the verdict
// is taken. Synchronous reset empties both registers and clears the sequence state.
`default_nettype none

module utf8_display_text_validator_core (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output                     logic o_in_ready,
    input  wire   utf8dv_pkg::t_byte i_text_byte,
    input  wire                logic i_last_byte,
    input  wire                logic i_empty_string,
    output                     logic o_out_valid,
    input  wire                logic i_out_ready,
    output                     logic o_string_valid
);
    import utf8dv_pkg::*;

    logic        r_in_valid;
    t_byte       r_byte;
    logic        r_last;
    logic        r_empty;

    t_pending    r_pending,   n_pending;
    t_code_point r_accum,     n_accum;
    t_min_class  r_min_class, n_min_class;
    logic        r_error,     n_error;

    logic        r_out_valid;
    logic        r_string_valid, n_string_valid;

    logic        produces_result;
    logic        out_free;
    logic        consume;
    t_code_point cp_next;

    assign produces_result = r_last | r_empty;
    assign out_free        = !r_out_valid || i_out_ready;
    assign consume         = r_in_valid && (!produces_result || out_free);
    assign o_in_ready      = !r_in_valid || consume;
    assign cp_next         = {r_accum[CpWidth-7:0], r_byte[5:0]};

    always_comb begin
        n_pending      = r_pending;
        n_accum        = r_accum;
        n_min_class    = r_min_class;
        n_error        = r_error;
        n_string_valid = 1'b1;

        if (!r_error) begin
            if (r_pending == 2'd0) begin
                priority if (r_byte <= C_DEL) begin
                    if (r_byte < C_SPACE || r_byte == C_DEL) begin
                        n_error = 1'b1;
                    end
                end else if (r_byte >= C_LEAD2_LO && r_byte <= C_LEAD2_HI) begin
                    n_accum     = t_code_point'(r_byte[4:0]);
                    n_pending   = 2'd1;
                    n_min_class = MIN_CLASS_2BYTE;
                end else if (r_byte >= C_LEAD3_LO && r_byte <= C_LEAD3_HI) begin
                    n_accum     = t_code_point'(r_byte[3:0]);
                    n_pending   = 2'd2;
                    n_min_class = MIN_CLASS_3BYTE;
                end else if (r_byte >= C_LEAD4_LO && r_byte <= C_LEAD4_HI) begin
                    n_accum     = t_code_point'(r_byte[2:0]);
                    n_pending   = 2'd3;
                    n_min_class = MIN_CLASS_4BYTE;
                end else begin
                    n_error = 1'b1;
                end
            end else if ((r_byte & C_CONT_MASK) != C_CONT_TAG) begin
                n_error   = 1'b1;
                n_pending = 2'd0;
            end else begin
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    if (cp_next < min_for_class(r_min_class) || cp_next > C_CP_MAX ||
                        (cp_next >= C_SURR_LO && cp_next <= C_SURR_HI)) begin
                        n_error = 1'b1;
                    end
                    n_accum     = '0;
                    n_min_class = MIN_CLASS_2BYTE;
                end else begin
                    n_accum = cp_next;
                end
            end
        end

        if (r_empty) begin
            n_string_valid = 1'b1;
        end else begin
            n_string_valid = !n_error && (n_pending == 2'd0);
        end

        if (produces_result) begin
            n_pending   = 2'd0;
            n_accum     = '0;
            n_min_class = MIN_CLASS_2BYTE;
            n_error     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pending   <= 2'd0;
            r_accum     <= '0;
            r_min_class <= MIN_CLASS_2BYTE;
            r_error     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (consume) begin
                r_pending   <= n_pending;
                r_accum     <= n_accum;
                r_min_class <= n_min_class;
                r_error     <= n_error;
            end
            if (consume && produces_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte  <= i_text_byte;
            r_last  <= i_last_byte;
            r_empty <= i_empty_string;
        end
        if (consume && produces_result) begin
            r_string_valid <= n_string_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_string_valid = r_string_valid;

endmodule

`default_nettype wire

// ===== sv/utf8dv_checker.sv =====
// Port checker for the UTF-8 display text validator and its bind to the top level.
`default_nettype none
`include "utf8_display_text_validator_core_macros.svh"

module utf8dv_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [7:0] i_text_byte,
    input wire logic       i_last_byte,
    input wire logic       i_empty_string,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_string_valid
);

    logic in_xfer;
    logic ends_string;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign ends_string = i_last_byte || i_empty_string;

    // The output register is empty right after reset.
    `UTF8DV_ASSERT_ALWAYS(a_out_idle_after_reset, !i_rst_n |=> !o_out_valid, "verdict valid after reset")

    // A waiting input transfer keeps its payload.
    `UTF8DV_ASSERT(a_in_hold, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_text_byte) && $stable(i_last_byte) && $stable(i_empty_string), "input changed while waiting")

    // A stalled verdict stays and keeps its value.
    `UTF8DV_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_string_valid), "verdict changed while stalled")

    // A fresh verdict follows the transfer of a final byte or an empty string.
    `UTF8DV_ASSERT(a_out_has_source, $rose(o_out_valid) |-> $past(in_xfer && ends_string, 2), "verdict without a final byte")

    // An empty string always yields a valid verdict.
    `UTF8DV_ASSERT(a_empty_is_valid, $rose(o_out_valid) && $past(in_xfer && i_empty_string, 2) |-> o_string_valid, "empty string reported invalid")

endmodule

bind utf8_display_text_validator_core utf8dv_checker u_utf8dv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_text_byte    (i_text_byte),
    .i_last_byte    (i_last_byte),
    .i_empty_string (i_empty_string),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_string_valid (o_string_valid)
);

`default_nettype wire

// ===== test/utf8_display_text_validator_checker.sv =====
// Checker that predicts and compares the verdicts of the UTF-8 display text validator.
`timescale 1ns / 100ps

module utf8_display_text_validator_checker
    import utf8dv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  t_byte i_text_byte,
    input  logic  i_last_byte,
    input  logic  i_empty_string,
    input  logic  i_out_valid,
    input  logic  i_out_ready,
    input  logic  i_string_valid,
    output int    o_fail_count,
    output int    o_verdicts_owed
);

    t_pending    cont_left;
    t_code_point cp_acc;
    t_min_class  seq_class;
    logic        bad_seen;
    logic        verdict_queue[$];
    int          fails = 0;

    task automatic clear_decoder();
        cont_left = '0;
        cp_acc = '0;
        seq_class = MIN_CLASS_2BYTE;
        bad_seen = 1'b0;
    endtask

    task automatic decode_byte(input t_byte b);
        t_code_point floor_cp;
        if (bad_seen) begin
            return;
        end
        if (cont_left == 2'd0) begin
            if (b <= C_DEL) begin
                if (b < C_SPACE || b == C_DEL) begin
                    bad_seen = 1'b1;
                end
            end else if (b >= C_LEAD2_LO && b <= C_LEAD2_HI) begin
                cp_acc = t_code_point'(b[4:0]);
                cont_left = 2'd1;
                seq_class = MIN_CLASS_2BYTE;
            end else if (b >= C_LEAD3_LO && b <= C_LEAD3_HI) begin
                cp_acc = t_code_point'(b[3:0]);
                cont_left = 2'd2;
                seq_class = MIN_CLASS_3BYTE;
            end else if (b >= C_LEAD4_LO && b <= C_LEAD4_HI) begin
                cp_acc = t_code_point'(b[2:0]);
                cont_left = 2'd3;
                seq_class = MIN_CLASS_4BYTE;
            end else begin
                bad_seen = 1'b1;
            end
            return;
        end
        if ((b & C_CONT_MASK) != C_CONT_TAG) begin
            bad_seen = 1'b1;
            cont_left = 2'd0;
            return;
        end
        cp_acc = {cp_acc[CpWidth-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
            case (seq_class)
                MIN_CLASS_2BYTE: floor_cp = C_MIN_2BYTE;
                MIN_CLASS_3BYTE: floor_cp = C_MIN_3BYTE;
                default:         floor_cp = C_MIN_4BYTE;
            endcase
            if (cp_acc < floor_cp || cp_acc > C_CP_MAX ||
                (cp_acc >= C_SURR_LO && cp_acc <= C_SURR_HI)) begin
                bad_seen = 1'b1;
            end
            cp_acc = '0;
            seq_class = MIN_CLASS_2BYTE;
        end
    endtask

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            clear_decoder();
            verdict_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_queue.size() == 0) begin
                    $error("string_valid: no verdict expected, actual %0b", i_string_valid);
                    fails++;
                end else begin
                    want = verdict_queue.pop_front();
                    if (i_string_valid !== want) begin
                        $error("string_valid mismatch: expected %0b, actual %0b",
                               want, i_string_valid);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_empty_string) begin
                    verdict_queue.push_back(1'b1);
                    clear_decoder();
                end else begin
                    decode_byte(i_text_byte);
                    if (i_last_byte) begin
                        verdict_queue.push_back(!bad_seen && cont_left == 2'd0);
                        clear_decoder();
                    end
                end
            end
        end
        o_verdicts_owed <= verdict_queue.size();
        o_fail_count <= fails;
    end

endmodule

// ===== test/tb_utf8_display_text_validator_core.sv =====
// Testbench top that drives strings into the UTF-8 display text validator and gives the verdict.
`timescale 1ns / 100ps

module tb_utf8_display_text_validator_core;
    import utf8dv_pkg::*;

    localparam int IdleLimit = 2000;
    localparam int PhaseItems = 470;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_byte i_text_byte;
    logic  i_last_byte;
    logic  i_empty_string;
    logic  o_out_valid;
    logic  i_out_ready;
    logic  o_string_valid;

    int    fail_count;
    int    verdicts_owed;
    int    items_sent = 0;
    int    idle_pct = 0;
    int    stall_pct = 0;
    t_byte str_bytes[$];

    t_code_point boundary_cps[10] = '{21'h80, 21'h7ff, 21'h800, 21'hffff, 21'hd7ff,
                                      21'he000, 21'hd800, 21'hdfff, 21'h10000, 21'h10ffff};

    utf8_display_text_validator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_last_byte    (i_last_byte),
        .i_empty_string (i_empty_string),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_string_valid (o_string_valid)
    );

    utf8_display_text_validator_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_text_byte     (i_text_byte),
        .i_last_byte     (i_last_byte),
        .i_empty_string  (i_empty_string),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_string_valid  (o_string_valid),
        .o_fail_count    (fail_count),
        .o_verdicts_owed (verdicts_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_byte(input t_byte b, input logic last, input logic empty);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_text_byte <= b;
        i_last_byte <= last;
        i_empty_string <= empty;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_string(input t_byte s[$]);
        foreach (s[k]) begin
            push_byte(s[k], k == s.size() - 1, 1'b0);
        end
    endtask

    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_owed != 0) @(posedge i_clk);
    endtask

    function automatic void append_code_point(input t_code_point cp, input int nb);
        case (nb)
            2: begin
                str_bytes.push_back({3'b110, cp[10:6]});
            end
            3: begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
            end
            default: begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
            end
        endcase
        str_bytes.push_back({2'b10, cp[5:0]});
    endfunction

    function automatic void append_char();
        int          r;
        int          nb;
        int          keep;
        int          v;
        t_code_point cp;
        t_byte       junk;
        r = $urandom_range(99);
        if (r < 35) begin
            str_bytes.push_back(t_byte'($urandom_range(8'h7e, 8'h20)));
        end else if (r < 50) begin
            append_code_point(t_code_point'($urandom_range(32'h7ff, 32'h80)), 2);
        end else if (r < 65) begin
            append_code_point(t_code_point'($urandom_range(32'hffff, 32'h800)), 3);
        end else if (r < 78) begin
            append_code_point(t_code_point'($urandom_range(32'h10ffff, 32'h10000)), 4);
        end else if (r < 83) begin
            cp = boundary_cps[$urandom_range(9)];
            nb = (cp < C_MIN_3BYTE) ? 2 : (cp < C_MIN_4BYTE) ? 3 : 4;
            append_code_point(cp, nb);
        end else if (r < 87) begin
            nb = $urandom_range(4, 2);
            v = (nb == 2) ? 32'h7f : (nb == 3) ? 32'h7ff : 32'hffff;
            append_code_point(t_code_point'($urandom_range(v, 0)), nb);
        end else if (r < 90) begin
            append_code_point(t_code_point'($urandom_range(32'h1fffff, 32'h110000)), 4);
        end else if (r < 93) begin
            v = $urandom_range(32, 0);
            str_bytes.push_back((v == 32) ? C_DEL : t_byte'(v));
        end else if (r < 96) begin
            str_bytes.push_back(t_byte'($urandom_range(255, 0)));
        end else begin
            nb = $urandom_range(4, 2);
            append_code_point(t_code_point'($urandom), nb);
            keep = $urandom_range(nb - 1, 1);
            if ($urandom_range(1)) begin
                junk = t_byte'($urandom_range(255, 0));
                if (junk[7:6] == 2'b10) begin
                    junk[7] = 1'b0;
                end
                str_bytes[str_bytes.size() - nb + keep] = junk;
            end else begin
                repeat (nb - keep) str_bytes.pop_back();
            end
        end
    endfunction

    task automatic send_random_string();
        int n_chars;
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            push_byte(t_byte'($urandom_range(255, 0)), 1'($urandom_range(1)), 1'b1);
            return;
        end
        str_bytes.delete();
        n_chars = ($urandom_range(9) == 0) ? $urandom_range(14, 7) : $urandom_range(6, 1);
        repeat (n_chars) append_char();
        if (r < 7) begin
            for (int k = 0; k < str_bytes.size() - 1; k++) begin
                push_byte(str_bytes[k], 1'b0, 1'b0);
            end
            push_byte(t_byte'($urandom_range(255, 0)), 1'($urandom_range(1)), 1'b1);
        end else begin
            send_string(str_bytes);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_text_byte <= '0;
        i_last_byte <= 1'b0;
        i_empty_string <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(8'hff, 1'b0, 1'b1);
        send_string('{8'h00});
        send_string('{C_DEL});
        send_string('{C_SPACE, 8'h7e});
        send_string('{C_LEAD2_LO, 8'h80});
        send_string('{C_LEAD3_LO, 8'h80, 8'h80});
        send_string('{8'hed, 8'ha0, 8'h80});
        send_string('{C_LEAD4_HI, 8'h90, 8'h80, 8'h80});
        send_string('{8'hf5});
        send_string('{C_LEAD2_LO, 8'h41});
        send_string('{C_LEAD3_LO});
        push_byte(C_LEAD4_LO, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        drain_verdicts();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 62; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 62; end
                default: begin idle_pct = 18; stall_pct <= 18; end
            endcase
            while (items_sent < 23 + (ph + 1) * PhaseItems) send_random_string();
            drain_verdicts();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
